>>> rtl/escsf_pkg.sv
// ----------------------------------------------------------------------------
// escsf_pkg
// shared types and constants of the escape-stuffed command framer
// ----------------------------------------------------------------------------
package escsf_pkg;

    localparam int          BYTE_W        = 8;
    localparam int          LEN_W         = 24;
    localparam int          DESC_BYTES    = 5;
    localparam int          IDX_W         = 3;
    localparam int          QUEUE_DEPTH   = 2;
    localparam logic [7:0]  ESC_RESET     = 8'd126;

    localparam logic        REQ_START     = 1'b0;
    localparam logic        REQ_PAYLOAD   = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX_START   = 3'd4;
    localparam logic [IDX_W-1:0] LAST_IDX_PAYLOAD = 3'd0;

    // one accepted transaction, already classified for the link side
    typedef struct packed {
        logic [DESC_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [DESC_BYTES-1:0]             dbl;
        logic [IDX_W-1:0]                  last_idx;
        logic                              done;
        logic                              over;
    } desc_t;

endpackage

>>> rtl/escsf_if.sv
// ----------------------------------------------------------------------------
// escsf_in_if / escsf_out_if
// valid/ready channels of the framer
// ----------------------------------------------------------------------------
interface escsf_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  cmd_code;
    logic [23:0] frame_length;
    logic [7:0]  data_byte;

    modport source (output valid, output req_type, output cmd_code,
                    output frame_length, output data_byte, input ready);
    modport sink   (input valid, input req_type, input cmd_code,
                    input frame_length, input data_byte, output ready);
endinterface

interface escsf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        frame_done;
    logic        overrun;

    modport source (output valid, output out_byte, output last_of_run,
                    output frame_done, output overrun, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input frame_done, input overrun, output ready);
endinterface

>>> rtl/escsf_front.sv
// ----------------------------------------------------------------------------
// escsf_front
// accepts transactions, tracks the remaining count and builds descriptors
// ----------------------------------------------------------------------------
module escsf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    escsf_in_if.sink            in_ch,
    input  logic                q_full,
    output logic                push,
    output escsf_pkg::desc_t    push_desc
);

    logic [7:0]                     esc_reg;
    logic [escsf_pkg::LEN_W-1:0]    remaining_reg;
    logic [escsf_pkg::LEN_W-1:0]    remaining_next;
    logic                           rem_zero;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;
    assign rem_zero    = (remaining_reg == '0);

    always_comb
    begin
        push_desc      = '0;
        remaining_next = remaining_reg;
        unique case (in_ch.req_type)
            escsf_pkg::REQ_START:
            begin
                push_desc.bytes[0] = esc_reg;
                push_desc.bytes[1] = in_ch.cmd_code;
                push_desc.bytes[2] = in_ch.frame_length[7:0];
                push_desc.bytes[3] = in_ch.frame_length[15:8];
                push_desc.bytes[4] = in_ch.frame_length[23:16];
                push_desc.dbl[0]   = 1'b0;
                push_desc.dbl[1]   = (in_ch.cmd_code == esc_reg);
                push_desc.dbl[2]   = (in_ch.frame_length[7:0] == esc_reg);
                push_desc.dbl[3]   = (in_ch.frame_length[15:8] == esc_reg);
                push_desc.dbl[4]   = (in_ch.frame_length[23:16] == esc_reg);
                push_desc.last_idx = escsf_pkg::LAST_IDX_START;
                push_desc.done     = (in_ch.frame_length == '0);
                push_desc.over     = 1'b0;
                remaining_next     = in_ch.frame_length;
            end
            escsf_pkg::REQ_PAYLOAD:
            begin
                push_desc.bytes[0] = in_ch.data_byte;
                push_desc.dbl[0]   = (in_ch.data_byte == esc_reg);
                push_desc.last_idx = escsf_pkg::LAST_IDX_PAYLOAD;
                push_desc.over     = rem_zero;
                push_desc.done     = (remaining_reg == escsf_pkg::LEN_W'(1));
                if (!rem_zero)
                begin
                    remaining_next = remaining_reg - escsf_pkg::LEN_W'(1);
                end
            end
            default:
            begin
                push_desc = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= escsf_pkg::ESC_RESET;
            remaining_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                esc_reg <= cfg_wdata;
            end
            if (push)
            begin
                remaining_reg <= remaining_next;
            end
        end
    end

endmodule

>>> rtl/escsf_queue.sv
// ----------------------------------------------------------------------------
// escsf_queue
// short descriptor queue between the front and back parts
// ----------------------------------------------------------------------------
module escsf_queue
#(
    parameter int DEPTH = escsf_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  escsf_pkg::desc_t    push_desc,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output escsf_pkg::desc_t    head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    escsf_pkg::desc_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/escsf_back.sv
// ----------------------------------------------------------------------------
// escsf_back
// walks a descriptor one link byte per unstalled cycle into output registers
// ----------------------------------------------------------------------------
module escsf_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  escsf_pkg::desc_t    head_desc,
    output logic                pop,
    escsf_out_if.source         out_ch
);

    logic [escsf_pkg::IDX_W-1:0]    idx_reg;
    logic                           dup_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           last_reg;
    logic                           done_reg;
    logic                           over_reg;

    logic                           emit;
    logic                           cur_dbl;
    logic                           byte_end;
    logic                           run_end;

    assign emit     = head_valid && (!out_valid_reg || out_ch.ready);
    assign cur_dbl  = head_desc.dbl[idx_reg];
    assign byte_end = dup_reg || !cur_dbl;
    assign run_end  = byte_end && (idx_reg == head_desc.last_idx);
    assign pop      = emit && run_end;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = last_reg;
    assign out_ch.frame_done  = done_reg;
    assign out_ch.overrun     = over_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= head_desc.bytes[idx_reg];
            last_reg     <= run_end;
            done_reg     <= run_end && head_desc.done;
            over_reg     <= head_desc.over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (!byte_end)
                begin
                    dup_reg <= 1'b1;
                end
                else
                begin
                    dup_reg <= 1'b0;
                    idx_reg <= run_end ? '0 : idx_reg + escsf_pkg::IDX_W'(1);
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/escape_stuffed_command_framer_top.sv
// ----------------------------------------------------------------------------
// escape_stuffed_command_framer_top
// byte-link command framer with escape-byte stuffing
// ----------------------------------------------------------------------------
// A start transaction produces the escape byte, the command byte and the
// 24-bit length low byte first, with any command or length byte equal to the
// escape value sent twice; a payload transaction produces its data byte, sent
// twice on a match, and counts down the remaining length. The link side moves
// one byte per cycle when not stalled by the output; a payload transaction
// yields one or two bytes, a start transaction five to nine; the back part's
// byte sequencer sets the rate. Transactions are classified on acceptance
// and held in a short queue, so input is taken while earlier bytes go out.
module escape_stuffed_command_framer_top
#(
    parameter int QUEUE_DEPTH = escsf_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    escsf_in_if.sink    in_ch,
    escsf_out_if.source out_ch
);

    logic               push;
    logic               pop;
    logic               q_full;
    logic               head_valid;
    escsf_pkg::desc_t   push_desc;
    escsf_pkg::desc_t   head_desc;

    escsf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    escsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    escsf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

>>> rtl/escsf_checker.sv
// ----------------------------------------------------------------------------
// escsf_checker
// port-level checks of the framer, bound to the top level
// ----------------------------------------------------------------------------
module escsf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        last_of_run,
    input  logic        frame_done,
    input  logic        overrun
);

    logic [7:0] pending_reg;
    logic       in_xfer;
    logic       run_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign run_xfer = out_valid && out_ready && last_of_run;

    // transactions accepted whose final byte has not yet gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !run_xfer)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (run_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("output byte with no transaction outstanding");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done away from the final byte");

    a_done_not_over: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_done && overrun))
        else $error("frame_done together with overrun");

endmodule

bind escape_stuffed_command_framer_top escsf_checker u_escsf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run),
    .frame_done  (out_ch.frame_done),
    .overrun     (out_ch.overrun)
);
